// ===== hw/rtl/hrds_pkg.sv =====
package hrds_pkg;

   localparam int DATA_W  = 32;
   localparam int PROD_W  = 64;
   localparam int MAX_W   = 61;
   localparam int OUT_W   = 62;
   localparam int TDATA_W = 128;

   localparam logic [7:0] HDR_REPORT_ID = 8'h85;
   localparam logic [7:0] KEY_MASK      = 8'hFC;
   localparam logic [7:0] LONG_MASK     = 8'hF0;
   localparam logic [7:0] KEY_RSIZE     = 8'h74;
   localparam logic [7:0] KEY_COUNT     = 8'h94;
   localparam logic [7:0] KEY_INPUT     = 8'h80;
   localparam logic [7:0] KEY_OUTPUT    = 8'h90;
   localparam logic [1:0] SIZE_CODE_4   = 2'd3;
   localparam logic [2:0] ROUND_UP      = 3'd7;

   // parsed item heading for the multiplier
   typedef struct packed {
      logic              is_mul;
      logic              is_out;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] count;
      logic              last;
      logic              saw_id;
      logic              malformed;
   } parse_tok_type;

   // product heading for the max tracker
   typedef struct packed {
      logic              is_mul;
      logic              is_out;
      logic [PROD_W-1:0] bits;
      logic              last;
      logic              saw_id;
      logic              malformed;
   } prod_tok_type;

endpackage

// ===== hw/rtl/hrds_parser.sv =====
module hrds_parser
   import hrds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   output logic          tok_valid,
   output parse_tok_type tok,
   input  logic          tok_ready
);

   localparam logic [1:0] PH_HEADER   = 2'd0;
   localparam logic [1:0] PH_LONG_LEN = 2'd1;
   localparam logic [1:0] PH_LONG_TAG = 2'd2;
   localparam logic [1:0] PH_DATA     = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        header_ff, header_in;
   logic [7:0]        remain_ff, remain_in;
   logic [1:0]        index_ff, index_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [7:0]        id_ff, id_in;
   logic [DATA_W-1:0] size_ff, size_in;
   logic [DATA_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] gsize_ff, gsize_in;
   logic [DATA_W-1:0] gcount_ff, gcount_in;
   logic              saw_ff, saw_in;
   logic              tok_valid_ff;
   parse_tok_type     tok_ff, tok_in;
   logic              done;
   logic [7:0]        key;
   logic              req_fire;

   assign req_tready = !tok_valid_ff || tok_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign tok_valid  = tok_valid_ff;
   assign tok        = tok_ff;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      remain_in = remain_ff;
      index_in  = index_ff;
      acc_in    = acc_ff;
      id_in     = id_ff;
      size_in   = size_ff;
      count_in  = count_ff;
      gsize_in  = gsize_ff;
      gcount_in = gcount_ff;
      saw_in    = saw_ff;
      done      = 1'b0;
      tok_in    = '0;

      case (phase_ff)
         PH_HEADER: begin
            header_in = req_tdata;
            acc_in    = '0;
            index_in  = '0;
            if (req_tdata == HDR_REPORT_ID) begin
               saw_in = 1'b1;
            end
            if ((req_tdata & LONG_MASK) == LONG_MASK) begin
               phase_in = PH_LONG_LEN;
            end else if (req_tdata[1:0] == 2'd0) begin
               done = 1'b1;
            end else begin
               remain_in = (req_tdata[1:0] == SIZE_CODE_4) ? 8'd4 : {6'd0, req_tdata[1:0]};
               phase_in  = PH_DATA;
            end
         end
         PH_LONG_LEN: begin
            remain_in = req_tdata;
            phase_in  = PH_LONG_TAG;
         end
         PH_LONG_TAG: begin
            if (remain_ff == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         default: begin
            if ((header_ff & LONG_MASK) != LONG_MASK) begin
               acc_in   = acc_ff | (DATA_W'(req_tdata) << {index_ff, 3'b000});
               index_in = index_ff + 2'd1;
            end
            if (remain_ff != 8'd0) begin
               remain_in = remain_ff - 8'd1;
            end
            if (remain_in == 8'd0) begin
               done = 1'b1;
            end
         end
      endcase

      key = header_in & KEY_MASK;
      if (done) begin
         if (header_in == HDR_REPORT_ID) begin
            id_in    = acc_in[7:0];
            size_in  = gsize_ff;
            count_in = gcount_ff;
         end else if (key == KEY_RSIZE) begin
            size_in = acc_in;
            if (id_ff == 8'd0) begin
               gsize_in = acc_in;
            end
         end else if (key == KEY_COUNT) begin
            count_in = acc_in;
            if (id_ff == 8'd0) begin
               gcount_in = acc_in;
            end
         end else if (key == KEY_INPUT || key == KEY_OUTPUT) begin
            tok_in.is_mul = 1'b1;
            tok_in.is_out = (key == KEY_OUTPUT);
         end
         phase_in  = PH_HEADER;
         remain_in = '0;
         index_in  = '0;
      end

      tok_in.size      = size_ff;
      tok_in.count     = count_ff;
      tok_in.last      = req_tlast;
      tok_in.saw_id    = saw_in;
      tok_in.malformed = (phase_in != PH_HEADER);

      // end of descriptor: start over
      if (req_tlast) begin
         phase_in  = PH_HEADER;
         header_in = '0;
         remain_in = '0;
         index_in  = '0;
         acc_in    = '0;
         id_in     = '0;
         size_in   = '0;
         count_in  = '0;
         gsize_in  = '0;
         gcount_in = '0;
         saw_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         header_ff    <= '0;
         remain_ff    <= '0;
         index_ff     <= '0;
         acc_ff       <= '0;
         id_ff        <= '0;
         size_ff      <= '0;
         count_ff     <= '0;
         gsize_ff     <= '0;
         gcount_ff    <= '0;
         saw_ff       <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff  <= phase_in;
            header_ff <= header_in;
            remain_ff <= remain_in;
            index_ff  <= index_in;
            acc_ff    <= acc_in;
            id_ff     <= id_in;
            size_ff   <= size_in;
            count_ff  <= count_in;
            gsize_ff  <= gsize_in;
            gcount_ff <= gcount_in;
            saw_ff    <= saw_in;
         end
         if (req_tready) begin
            tok_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tok_ff <= tok_in;
      end
   end

endmodule

// ===== hw/rtl/hrds_mul.sv =====
module hrds_mul
   import hrds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          tok_valid,
   input  parse_tok_type tok,
   output logic          tok_ready,
   output logic          prod_valid,
   output prod_tok_type  prod,
   input  logic          prod_ready
);

   logic         prod_valid_ff;
   prod_tok_type prod_ff, prod_in;

   assign tok_ready  = !prod_valid_ff || prod_ready;
   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

   always_comb begin
      prod_in.is_mul    = tok.is_mul;
      prod_in.is_out    = tok.is_out;
      prod_in.bits      = PROD_W'(tok.size) * PROD_W'(tok.count);
      prod_in.last      = tok.last;
      prod_in.saw_id    = tok.saw_id;
      prod_in.malformed = tok.malformed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (tok_ready) begin
         prod_valid_ff <= tok_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_ready && tok_valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== hw/rtl/hrds_max.sv =====
module hrds_max
   import hrds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic               csr_wdata,
   input  logic               prod_valid,
   input  prod_tok_type       prod,
   output logic               prod_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata
);

   logic              count_id_ff;
   logic [MAX_W-1:0]  in_acc_ff, in_acc_in;
   logic [MAX_W-1:0]  out_acc_ff, out_acc_in;
   logic              rsp_valid_ff;
   logic [MAX_W-1:0]  rsp_in_ff, rsp_out_ff;
   logic              rsp_saw_ff, rsp_mal_ff;
   logic [PROD_W-1:0] rounded;
   logic [MAX_W-1:0]  bytes;
   logic              prod_fire;
   logic [OUT_W-1:0]  in_bytes, out_bytes;

   assign prod_ready = !(prod.last && rsp_valid_ff && !rsp_tready);
   assign prod_fire  = prod_valid && prod_ready;
   assign rounded    = prod.bits + PROD_W'(ROUND_UP);
   assign bytes      = rounded[PROD_W-1:3];

   always_comb begin
      in_acc_in  = in_acc_ff;
      out_acc_in = out_acc_ff;
      if (prod.is_mul && !prod.is_out && bytes > in_acc_ff) begin
         in_acc_in = bytes;
      end
      if (prod.is_mul && prod.is_out && bytes > out_acc_ff) begin
         out_acc_in = bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_id_ff  <= 1'b1;
         in_acc_ff    <= '0;
         out_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            count_id_ff <= csr_wdata;
         end
         if (prod_fire) begin
            in_acc_ff  <= prod.last ? '0 : in_acc_in;
            out_acc_ff <= prod.last ? '0 : out_acc_in;
         end
         if (prod_fire && prod.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_fire && prod.last) begin
         rsp_in_ff  <= in_acc_in;
         rsp_out_ff <= out_acc_in;
         rsp_saw_ff <= prod.saw_id;
         rsp_mal_ff <= prod.malformed;
      end
   end

   // report ID prefix byte
   assign in_bytes  = OUT_W'(rsp_in_ff) +
                      OUT_W'(count_id_ff && (rsp_in_ff != '0));
   assign out_bytes = OUT_W'(rsp_out_ff) +
                      OUT_W'(count_id_ff && (rsp_out_ff != '0));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_mal_ff, rsp_saw_ff, out_bytes, in_bytes};

endmodule

// ===== hw/rtl/hid_report_descriptor_sizer_core.sv =====
// HID report descriptor sizer. Takes one descriptor byte per item on req_,
// with req_tlast on the final byte, at a sustained rate of one byte per
// clock unless rsp_tready holds the pipeline back. One rsp_ item is
// produced per descriptor; rsp_tvalid rises once its last byte has passed
// a parse register, a 32x32 multiply register and the max/result register.
// csr_wdata (count_id_byte, reset 1) adds one byte to each nonzero maximum;
// write it only while the block is idle.
module hid_report_descriptor_sizer_core
   import hrds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic               csr_wdata,    // count_id_byte
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,    // [7:0] desc_byte
   input  logic               req_tlast,    // last_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [61:0] max_input_bytes, [123:62] max_output_bytes,
   // [124] uses_report_ids, [125] malformed, [127:126] zero
   output logic [TDATA_W-1:0] rsp_tdata
);

   logic          tok_valid, tok_ready;
   parse_tok_type tok;
   logic          prod_valid, prod_ready;
   prod_tok_type  prod;

   hrds_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .tok_valid  (tok_valid),
      .tok        (tok),
      .tok_ready  (tok_ready)
   );

   hrds_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (tok_valid),
      .tok        (tok),
      .tok_ready  (tok_ready),
      .prod_valid (prod_valid),
      .prod       (prod),
      .prod_ready (prod_ready)
   );

   hrds_max u_max (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .prod_valid (prod_valid),
      .prod       (prod),
      .prod_ready (prod_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
